/* design/ifm_pkg.sv */
package ifm_pkg;

	localparam int MAX_REGIONS = 1024;
	localparam int CHROM_BITS = 8;

	// Stored chromosome id width: the input field carries at most 8 bits.
	localparam int CHROM_W = (CHROM_BITS < 8) ? CHROM_BITS : 8;
	localparam int SLOT_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_MATCH = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_NOT_LOADED = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_MATCH,
		OP_READ,
		OP_NONE
	} op_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] chrom_id;
		logic [31:0] region_start;
		logic [31:0] region_end;
		logic [31:0] query_position;
		logic strand_bit;
		logic [7:0] call_code;
		logic [9:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status_code;
		logic hit_flag;
		logic off_target_flag;
		logic [9:0] slot_out;
		logic [31:0] hit_count;
		logic [7:0] echo_chrom;
		logic [31:0] echo_position;
		logic echo_strand;
		logic [7:0] echo_call;
	} out_item_t;

	// One classified operation as it waits between front and back.
	typedef struct packed {
		op_t op;
		logic [CHROM_W-1:0] chrom;
		logic [31:0] first;
		logic [31:0] last;
		logic [31:0] pos;
		logic strand;
		logic [7:0] call;
		logic [9:0] idx;
	} op_entry_t;

	typedef struct packed {
		logic [CHROM_W-1:0] chrom;
		logic [31:0] first;
		logic [31:0] last;
	} region_t;

endpackage

/* design/ifm_front.sv */
module ifm_front import ifm_pkg::*; (
	input logic item_valid,
	input in_item_t item,
	output logic item_stall,
	input logic q_full,
	output logic q_push,
	output op_entry_t q_entry
);

	op_t op;

	always_comb begin
		case (item.command)
			CMD_ADD: op = OP_ADD;
			CMD_MATCH: op = OP_MATCH;
			CMD_READ: op = OP_READ;
			default: op = OP_NONE;
		endcase
	end

	assign item_stall = q_full;
	assign q_push = item_valid && !q_full;

	always_comb begin
		q_entry.op = op;
		q_entry.chrom = item.chrom_id[CHROM_W-1:0];
		q_entry.first = item.region_start;
		q_entry.last = item.region_end;
		q_entry.pos = item.query_position;
		q_entry.strand = item.strand_bit;
		q_entry.call = item.call_code;
		q_entry.idx = item.read_index;
	end

endmodule

/* design/ifm_queue.sv */
module ifm_queue import ifm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input op_entry_t push_entry,
	output logic full,
	input logic pop,
	output logic valid,
	output op_entry_t head
);

	op_entry_t mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full = (count_q == Q_CNT_W'(Q_DEPTH));
	assign valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/ifm_back.sv */
module ifm_back import ifm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input op_entry_t q_head,
	output logic q_pop,
	output logic result_valid,
	input logic result_stall,
	output out_item_t result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_INC,
		ST_READ
	} state_t;

	state_t state_q;
	op_entry_t op_q;
	logic [SLOT_W-1:0] scan_q;
	logic [CNT_W-1:0] used_q;
	logic result_valid_q;
	out_item_t result_q;

	region_t tab_mem [MAX_REGIONS];
	region_t tab_rd_q;
	logic [31:0] hits_mem [MAX_REGIONS];
	logic [31:0] hits_rd_q;

	logic out_free;
	logic table_full;
	logic idx_loaded;
	logic slot_hit;
	logic scan_last;
	logic [SLOT_W-1:0] used_addr;
	logic [SLOT_W-1:0] idx_addr;
	logic [SLOT_W-1:0] tab_raddr;
	logic [SLOT_W-1:0] hits_raddr;
	logic tab_we;
	logic hits_we;
	logic [SLOT_W-1:0] hits_waddr;
	logic [31:0] hits_wdata;
	logic [31:0] hits_next;
	region_t new_region;
	logic load_result;
	out_item_t result_d;

	function automatic out_item_t miss_result(op_entry_t e);
		out_item_t r;
		r = '0;
		r.off_target_flag = 1'b1;
		r.echo_chrom = 8'(e.chrom);
		r.echo_position = e.pos;
		r.echo_strand = e.strand;
		r.echo_call = e.call;
		return r;
	endfunction

	assign result_valid = result_valid_q;
	assign result = result_q;

	// The output register is free when empty or when its transfer happens now.
	assign out_free = !result_valid_q || !result_stall;
	assign q_pop = (state_q == ST_IDLE) && q_valid && out_free;

	assign table_full = (32'(used_q) >= 32'(MAX_REGIONS));
	assign idx_loaded = (32'(q_head.idx) < 32'(used_q));
	assign used_addr = SLOT_W'(used_q);
	assign idx_addr = SLOT_W'(q_head.idx);

	assign slot_hit = (tab_rd_q.chrom == op_q.chrom) && (tab_rd_q.first <= op_q.pos)
		&& (op_q.pos <= tab_rd_q.last);
	assign scan_last = ((32'(scan_q) + 32'd1) == 32'(used_q));
	assign hits_next = (hits_rd_q == 32'hFFFF_FFFF) ? hits_rd_q : hits_rd_q + 32'd1;

	// The scan reads one slot ahead so that a compare completes every cycle.
	assign tab_raddr = (state_q == ST_SCAN) ? scan_q + 1'b1 : '0;
	assign hits_raddr = (state_q == ST_SCAN) ? scan_q : idx_addr;

	assign tab_we = q_pop && (q_head.op == OP_ADD) && !table_full;

	always_comb begin
		new_region.chrom = q_head.chrom;
		new_region.first = q_head.first;
		new_region.last = q_head.last;
		hits_we = 1'b0;
		hits_waddr = used_addr;
		hits_wdata = '0;
		if (tab_we) begin
			hits_we = 1'b1;
		end else if (state_q == ST_INC) begin
			hits_we = 1'b1;
			hits_waddr = scan_q;
			hits_wdata = hits_next;
		end
	end

	always_comb begin
		load_result = 1'b0;
		result_d = '0;
		case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					case (q_head.op)
						OP_ADD: begin
							load_result = 1'b1;
							if (table_full) begin
								result_d.status_code = STATUS_FULL;
							end else begin
								result_d.slot_out = 10'(used_q);
							end
						end
						OP_MATCH: begin
							if (used_q == '0) begin
								load_result = 1'b1;
								result_d = miss_result(q_head);
							end
						end
						OP_READ: begin
							if (!idx_loaded) begin
								load_result = 1'b1;
								result_d.status_code = STATUS_NOT_LOADED;
								result_d.slot_out = q_head.idx;
							end
						end
						default: begin
							load_result = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (!slot_hit && scan_last) begin
					load_result = 1'b1;
					result_d = miss_result(op_q);
				end
			end
			ST_INC: begin
				load_result = 1'b1;
				result_d.hit_flag = 1'b1;
				result_d.slot_out = 10'(scan_q);
				result_d.hit_count = hits_next;
			end
			ST_READ: begin
				load_result = 1'b1;
				result_d.status_code = STATUS_OK;
				result_d.slot_out = op_q.idx;
				result_d.hit_count = hits_rd_q;
			end
			default: begin
				load_result = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tab_we) begin
			tab_mem[used_addr] <= new_region;
		end
		tab_rd_q <= tab_mem[tab_raddr];
	end

	always_ff @(posedge clk) begin
		if (hits_we) begin
			hits_mem[hits_waddr] <= hits_wdata;
		end
		hits_rd_q <= hits_mem[hits_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			result_valid_q <= 1'b0;
			result_q <= '0;
			op_q <= '0;
			scan_q <= '0;
		end else begin
			if (load_result) begin
				result_valid_q <= 1'b1;
				result_q <= result_d;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						op_q <= q_head;
						case (q_head.op)
							OP_ADD: begin
								if (!table_full) begin
									used_q <= used_q + 1'b1;
								end
							end
							OP_MATCH: begin
								if (used_q != '0) begin
									scan_q <= '0;
									state_q <= ST_SCAN;
								end
							end
							OP_READ: begin
								if (idx_loaded) begin
									state_q <= ST_READ;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (slot_hit) begin
						state_q <= ST_INC;
					end else if (scan_last) begin
						state_q <= ST_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_INC: begin
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/interval_match_counter.sv */
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     item   (in_item_t)
// result    out        result_valid / result_stall result (out_item_t)
//
// The back end takes an add, the unused command or a read of an unloaded slot at
// the pop alone; a read of a loaded slot passes ST_READ; a match that hits slot k
// scans slots 0 to k, then ST_INC; a miss scans all n loaded slots (n <= 1024).
// The region table has one read port and the scan compares one slot per cycle.
// Reset empties the table at once; no clearing pass is needed.
// A held result blocks the back end; the two-entry queue then fills and stalls items.
module interval_match_counter import ifm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input in_item_t item,
	output logic result_valid,
	input logic result_stall,
	output out_item_t result
);

	logic q_full;
	logic q_push;
	op_entry_t q_entry;
	logic q_pop;
	logic q_valid;
	op_entry_t q_head;

	ifm_front u_front (
		.item_valid(item_valid),
		.item(item),
		.item_stall(item_stall),
		.q_full(q_full),
		.q_push(q_push),
		.q_entry(q_entry)
	);

	ifm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_entry(q_entry),
		.full(q_full),
		.pop(q_pop),
		.valid(q_valid),
		.head(q_head)
	);

	ifm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_head(q_head),
		.q_pop(q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule
